// ===== rtl/core/spe_pkg.sv =====
// Shared constants, cell type, frequency table builder and arctangent table for the embedding core.
package spe_pkg;

  localparam int EMBED_DIM     = 64;
  localparam int CORDIC_STAGES = 16;
  localparam int PAIR_COUNT    = (EMBED_DIM + 1) / 2;
  localparam int PAIR_W        = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  localparam int IDX_W   = 6;
  localparam int VALUE_W = 16;
  localparam int POS_W   = 16;
  localparam int PHASE_W = 32;
  localparam int XY_W    = 34;
  localparam int Z_W     = 34;
  localparam int ATAN_COUNT = 24;
  localparam int STAGE_W = $clog2(ATAN_COUNT);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EMBED_DIM - 1);

  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] POWER_TARGET   = 64'hFFFFFFFFFFFFFFFF / 64'd100000000;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(32'h26DD3B6A);

  typedef logic [PAIR_COUNT-1:0][PHASE_W-1:0] spe_freq_rom_t;

  // One beat of work travelling down the rotation chain.
  typedef struct packed {
    logic                   vld;
    logic [IDX_W-1:0]       idx;
    logic [1:0]             quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } spe_cell_t;

  function automatic logic [63:0] mul_high(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[127:64];
  endfunction

  function automatic logic [63:0] power_q64(input logic [63:0] y);
    logic [63:0] r;
    r = y;
    for (int i = 1; i < EMBED_DIM; i++) begin
      r = mul_high(r, y);
    end
    return r;
  endfunction

  // Frequencies in turns per position, Q0.32. Evaluated at elaboration only.
  function automatic spe_freq_rom_t build_freq_rom();
    spe_freq_rom_t rom;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    logic [63:0] mid;
    logic [63:0] wk;
    logic [63:0] f;
    logic [63:0] fr;
    lo = 64'd0;
    hi = 64'hFFFFFFFFFFFFFFFF;
    for (int it = 0; it < 70; it++) begin
      if (lo < hi) begin
        span = hi - lo;
        mid  = lo + (span >> 1) + (span & 64'd1);
        if (power_q64(mid) <= POWER_TARGET) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    wk = lo;
    for (int j = 0; j < PAIR_COUNT; j++) begin
      f      = mul_high(wk, INV_TWO_PI_Q64);
      fr     = f + 64'h0000000080000000;
      rom[j] = fr[63:32];
      wk     = mul_high(wk, lo);
    end
    return rom;
  endfunction

  localparam spe_freq_rom_t FREQ_ROM = build_freq_rom();

  // Arctangent of 2^-i in turns, Q0.32.
  function automatic logic [PHASE_W-1:0] atan_turn(input logic [STAGE_W-1:0] i);
    logic [PHASE_W-1:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/spe_phase_gen.sv =====
// Position register, element counter and phase multiply feeding the rotation chain.
module spe_phase_gen import spe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [POS_W-1:0] in_position,
  output spe_cell_t        cell_out
);

  logic               busy_r;
  logic [IDX_W-1:0]   k_r;
  logic [POS_W-1:0]   pos_r;
  spe_cell_t          cell_r;
  spe_cell_t          cell_nxt;
  logic               issue_fire;
  logic               issue_last;
  logic               in_acc;
  logic [PAIR_W-1:0]  pair;
  logic [POS_W+PHASE_W-1:0] product;

  assign issue_fire = busy_r && adv;
  assign issue_last = issue_fire && (k_r == LAST_IDX);
  // A new position may enter in the cycle its predecessor issues its last element.
  assign in_stall   = busy_r && !issue_last;
  assign in_acc     = in_valid && !in_stall;

  assign pair    = k_r[PAIR_W:1];
  assign product = pos_r * FREQ_ROM[pair];

  always_comb begin
    cell_nxt.vld  = issue_fire;
    cell_nxt.idx  = k_r;
    cell_nxt.quad = product[PHASE_W-1:PHASE_W-2];
    cell_nxt.x    = CORDIC_X0;
    cell_nxt.y    = '0;
    cell_nxt.z    = Z_W'(product[PHASE_W-3:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      cell_r <= '0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
        k_r    <= '0;
        pos_r  <= in_position;
      end else if (issue_fire) begin
        k_r <= k_r + IDX_W'(1);
        if (issue_last) begin
          busy_r <= 1'b0;
        end
      end
      if (adv) begin
        cell_r <= cell_nxt;
      end
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== rtl/core/spe_cordic_cell.sv =====
// One rotation step of the CORDIC chain, registered towards the next cell.
module spe_cordic_cell import spe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [STAGE_W-1:0] stage_idx,
  input  spe_cell_t          cell_in,
  output spe_cell_t          cell_out
);

  spe_cell_t              cell_r;
  spe_cell_t              cell_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  at;

  assign dx = cell_in.y >>> stage_idx;
  assign dy = cell_in.x >>> stage_idx;
  assign at = Z_W'(atan_turn(stage_idx));

  always_comb begin
    cell_nxt = cell_in;
    if (!cell_in.z[Z_W-1]) begin
      cell_nxt.x = cell_in.x - dx;
      cell_nxt.y = cell_in.y + dy;
      cell_nxt.z = cell_in.z - at;
    end else begin
      cell_nxt.x = cell_in.x + dx;
      cell_nxt.y = cell_in.y - dy;
      cell_nxt.z = cell_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== rtl/core/spe_round_out.sv =====
// Quadrant mapping, Q1.15 rounding with saturation and the result output register.
module spe_round_out import spe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spe_cell_t                 cell_in,
  output logic                      adv,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          out_element_index,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_last
);

  logic                      out_valid_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [VALUE_W-1:0] value_r;
  logic                      last_r;
  logic signed [XY_W-1:0]    s_val;
  logic signed [XY_W-1:0]    c_val;
  logic signed [XY_W-1:0]    sel;
  logic signed [XY_W:0]      biased;
  logic signed [XY_W:0]      shifted;
  logic signed [VALUE_W-1:0] value_nxt;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    unique case (cell_in.quad)
      2'd0: begin
        s_val = cell_in.y;
        c_val = cell_in.x;
      end
      2'd1: begin
        s_val = cell_in.x;
        c_val = -cell_in.y;
      end
      2'd2: begin
        s_val = -cell_in.y;
        c_val = -cell_in.x;
      end
      default: begin
        s_val = -cell_in.x;
        c_val = cell_in.y;
      end
    endcase
    sel     = cell_in.idx[0] ? c_val : s_val;
    biased  = (XY_W+1)'(sel) + (XY_W+1)'(16384);
    shifted = biased >>> 15;
    if (shifted > (XY_W+1)'(32767)) begin
      value_nxt = 16'sh7FFF;
    end else if (shifted < -(XY_W+1)'(32768)) begin
      value_nxt = 16'sh8000;
    end else begin
      value_nxt = shifted[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cell_in.vld;
      if (cell_in.vld) begin
        idx_r   <= cell_in.idx;
        value_r <= value_nxt;
        last_r  <= (cell_in.idx == LAST_IDX);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_index = idx_r;
  assign out_value         = value_r;
  assign out_last          = last_r;

endmodule

// ===== rtl/core/sinusoidal_position_embedding_core.sv =====
// Sinusoidal position embedding generator: phase unit, CORDIC cell chain and output stage.
//
// Usage: present a sequence position on in_position with in_valid; it is taken on a
// clock edge where in_valid is high and in_stall is low. For each position the core
// returns EMBED_DIM result beats in element order on the out_ channel: even elements
// carry the sine, odd elements the cosine of the pair's phase, as signed Q1.15, and
// out_last marks the final element.
// After acceptance each element passes through the phase register, the chain of CORDIC
// cells and the output register before it is presented.
// Throughput is one result beat per cycle while the output does not stall; the element
// counter issuing into the chain sets that rate, and the next position is taken in the
// cycle its predecessor issues its last element.
// When the receiver raises out_stall on a presented beat the whole chain holds, the output
// beat stays unchanged and in_stall stays high while a position is still issuing.
// Reset (synchronous, rst_n low) empties the chain and the counter; the frequency
// table is a constant and needs no loading.
module sinusoidal_position_embedding_core import spe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [POS_W-1:0]          in_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          out_element_index,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_last
);

  logic      adv;
  spe_cell_t chain_w [CORDIC_STAGES+1];

  spe_phase_gen u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_position (in_position),
    .cell_out    (chain_w[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    spe_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .stage_idx (STAGE_W'(g)),
      .cell_in   (chain_w[g]),
      .cell_out  (chain_w[g+1])
    );
  end

  spe_round_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .cell_in           (chain_w[CORDIC_STAGES]),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_index (out_element_index),
    .out_value         (out_value),
    .out_last          (out_last)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the sinusoidal position embedding core.
module tb;
  import spe_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    logic               last;
  } embed_elem_t;

  localparam int QUIET_FROM  = 3000;
  localparam int QUIET_TO    = 6000;
  localparam int HOLD_AFTER  = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_POSITIONS = 144;
  localparam int DIRECTED_COUNT = 16;
  localparam int STAGE_LIMIT = 24;
  localparam longint GAIN_X0 = 64'h26DD3B6A;
  localparam logic [63:0] RECIP_TWO_PI = 64'h28BE60DB9391054A;
  localparam logic [31:0] ATAN_STEP [STAGE_LIMIT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };
  localparam logic [POS_W-1:0] DIRECTED_POS [DIRECTED_COUNT] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h7FFF,
    16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0100, 16'h0C91, 16'h1922, 16'h3243
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_element_index;
  logic signed [VALUE_W-1:0] out_value;
  logic out_last;

  logic [31:0] turn_rate [PAIR_COUNT];
  logic [POS_W-1:0] pend_pos [$];
  embed_elem_t embed_q [$];
  int err_cnt = 0;
  int cyc = 0;
  int beats_seen = 0;
  int hold_left = 0;
  bit held = 1'b0;
  wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  sinusoidal_position_embedding_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_index (out_element_index),
    .out_value         (out_value),
    .out_last          (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic logic [63:0] q64_mulhi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return wide[127:64];
  endfunction

  function automatic logic [VALUE_W-1:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[VALUE_W-1:0];
  endfunction

  // Rotation-mode CORDIC on the angle within the quadrant, then the quadrant fold.
  function automatic void sin_cos(input logic [31:0] phase,
                                  output logic [VALUE_W-1:0] s_q,
                                  output logic [VALUE_W-1:0] c_q);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = GAIN_X0;
    y = 0;
    z = longint'({34'd0, phase[29:0]});
    for (int i = 0; i < CORDIC_STAGES && i < STAGE_LIMIT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'({32'd0, ATAN_STEP[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'({32'd0, ATAN_STEP[i]});
      end
    end
    case (phase[31:30])
      2'd0: begin
        s_q = round_q15(y);
        c_q = round_q15(x);
      end
      2'd1: begin
        s_q = round_q15(x);
        c_q = round_q15(-y);
      end
      2'd2: begin
        s_q = round_q15(-y);
        c_q = round_q15(-x);
      end
      default: begin
        s_q = round_q15(-x);
        c_q = round_q15(y);
      end
    endcase
  endfunction

  function automatic void push_embedding(input logic [POS_W-1:0] pos);
    logic [31:0] phase;
    logic [VALUE_W-1:0] s_q;
    logic [VALUE_W-1:0] c_q;
    embed_elem_t e;
    for (int k = 0; k < EMBED_DIM && k < 64; k++) begin
      phase = 32'(64'(pos) * 64'(turn_rate[k >> 1]));
      sin_cos(phase, s_q, c_q);
      e.idx   = IDX_W'(k);
      e.value = k[0] ? c_q : s_q;
      e.last  = (k == EMBED_DIM - 1);
      embed_q.push_back(e);
    end
  endfunction

  // Frequency table: W is found by bisection on its EMBED_DIM-th power in Q0.64.
  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    logic [63:0] mid;
    logic [63:0] pw;
    logic [63:0] wk;
    logic [63:0] f;
    lo = 64'd0;
    hi = '1;
    while (lo < hi) begin
      span = hi - lo;
      mid = lo + (span >> 1) + (span & 64'd1);
      pw = mid;
      for (int i = 1; i < EMBED_DIM; i++) pw = q64_mulhi(pw, mid);
      if (pw <= 64'hFFFFFFFFFFFFFFFF / 64'd100000000) lo = mid;
      else hi = mid - 64'd1;
    end
    wk = lo;
    for (int j = 0; j < PAIR_COUNT; j++) begin
      f = q64_mulhi(wk, RECIP_TWO_PI) + 64'h80000000;
      turn_rate[j] = f[63:32];
      wk = q64_mulhi(wk, lo);
    end
  end

  // Sender: once the current beat has gone or none is up, may offer the next position.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) push_embedding(in_position);
      if (!in_valid || !in_stall) begin
        if (pend_pos.size() != 0 && (quiet || $urandom_range(99) >= 12)) begin
          in_position <= pend_pos.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off lets the chain back up and stall the sender.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_n && !held && beats_seen >= HOLD_AFTER) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: checks each beat against the oldest expected element and drives the stall.
  always @(posedge clk) begin
    embed_elem_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_seen <= beats_seen + 1;
        if (embed_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected beat: idx %0d value %0d last %0b",
                     out_element_index, out_value, out_last);
        end else begin
          e = embed_q.pop_front();
          if (out_element_index !== e.idx || out_value !== e.value || out_last !== e.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected idx %0d value %0d last %0b, got idx %0d value %0d last %0b",
                       e.idx, $signed(e.value), e.last,
                       out_element_index, out_value, out_last);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 12);
      end
    end
  end

  initial begin
    logic [POS_W-1:0] p;
    foreach (DIRECTED_POS[i]) pend_pos.push_back(DIRECTED_POS[i]);
    for (int i = 0; i < RANDOM_POSITIONS; i++) begin
      // A share of small positions keeps the low-frequency phases near zero.
      if ($urandom_range(3) == 0) p = POS_W'($urandom_range(255));
      else p = POS_W'($urandom_range(16'hFFFF));
      pend_pos.push_back(p);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (pend_pos.size() != 0 || in_valid);
    while (embed_q.size() != 0) @(posedge clk);
    repeat (2 * (CORDIC_STAGES + 3) + EMBED_DIM) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/spe_pkg.sv
rtl/core/spe_phase_gen.sv
rtl/core/spe_cordic_cell.sv
rtl/core/spe_round_out.sv
rtl/core/sinusoidal_position_embedding_core.sv
test/tb.sv
